/* src/vnfbm_pkg.sv */
`timescale 1ns / 1ps

package vnfbm_pkg;

    // Default octave count
    localparam int OCTAVES_DEF = 4;

    // Lattice hash multipliers
    localparam logic [31:0] K_IDX_MUL  = 32'd374761393;
    localparam logic [31:0] K_SEED_MUL = 32'd668265263;
    localparam logic [31:0] K_MIX_MUL  = 32'd1274126177;

    // Seed after reset, and its premultiplied form as held in the seed register
    localparam logic [31:0] SEED_RESET     = 32'd1337;
    localparam logic [63:0] SEED_PROD_WIDE = 64'(SEED_RESET) * 64'(K_SEED_MUL);
    localparam logic [31:0] SEED_MUL_RESET = SEED_PROD_WIDE[31:0];

    // Per-octave interpolated value: unsigned Q0.40
    localparam int VAL_W = 40;

endpackage

/* src/vnfbm_cell.sv */
`timescale 1ns / 1ps

module vnfbm_cell import vnfbm_pkg::*; #(
    parameter int OCTAVES = OCTAVES_DEF,
    parameter int IDX     = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_ce,
    input  logic                      i_valid,
    input  logic [31:0]               i_pos,
    input  logic [31:0]               i_seed_mul,
    input  logic [VAL_W+OCTAVES-1:0]  i_acc,
    output logic                      o_valid,
    output logic [31:0]               o_pos,
    output logic                      o_acc_valid,
    output logic [VAL_W+OCTAVES-1:0]  o_acc
);

    localparam int AW = VAL_W + OCTAVES;
    localparam int SH = OCTAVES - 1 - IDX;

    // Stage 1: scale position, split floor / fraction, first hash multiply
    logic [47:0] w_pos_ext;
    logic [47:0] w_p;
    logic [31:0] w_lo;
    logic [31:0] w_m1;

    assign w_pos_ext = {{16{i_pos[31]}}, i_pos};
    assign w_p       = w_pos_ext << IDX;
    assign w_lo      = w_p[47:16];
    assign w_m1      = w_lo * K_IDX_MUL;

    logic        r_v1;
    logic [31:0] r_pos1;
    logic [15:0] r_t1;
    logic [31:0] r_ha1;
    logic [31:0] r_hb1;

    // Stage 2: xor-shift and mix multiply for both lattice points
    logic [31:0] w_xa;
    logic [31:0] w_xb;

    assign w_xa = r_ha1 ^ (r_ha1 >> 13);
    assign w_xb = r_hb1 ^ (r_hb1 >> 13);

    logic        r_v2;
    logic [15:0] r_t2;
    logic [31:0] r_ha2;
    logic [31:0] r_hb2;

    // Stage 3: final fold, slope times fraction
    logic [31:0]        w_fa;
    logic [31:0]        w_fb;
    logic signed [24:0] w_diff;
    logic signed [16:0] w_t_s;
    logic signed [41:0] w_slope;

    assign w_fa    = r_ha2 ^ (r_ha2 >> 16);
    assign w_fb    = r_hb2 ^ (r_hb2 >> 16);
    assign w_diff  = $signed({1'b0, w_fb[23:0]}) - $signed({1'b0, w_fa[23:0]});
    assign w_t_s   = $signed({1'b0, r_t2});
    assign w_slope = w_diff * w_t_s;

    logic               r_v3;
    logic [23:0]        r_a3;
    logic signed [41:0] r_d3;

    // Stage 4: interpolate, weight and add to the running sum from the left
    logic signed [41:0] w_v;
    logic [AW-1:0]      w_v_ext;

    assign w_v     = $signed({2'b00, r_a3, 16'h0000}) + r_d3;
    assign w_v_ext = AW'(w_v[VAL_W-1:0]);

    logic          r_v4;
    logic [AW-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_ce) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_pos1 <= i_pos;
            r_t1   <= w_p[15:0];
            r_ha1  <= w_m1 + i_seed_mul;
            r_hb1  <= w_m1 + i_seed_mul + K_IDX_MUL;
            r_t2   <= r_t1;
            r_ha2  <= w_xa * K_MIX_MUL;
            r_hb2  <= w_xb * K_MIX_MUL;
            r_a3   <= w_fa[23:0];
            r_d3   <= w_slope;
            r_acc  <= i_acc + (w_v_ext << SH);
        end
    end

    assign o_valid     = r_v1;
    assign o_pos       = r_pos1;
    assign o_acc_valid = r_v4;
    assign o_acc       = r_acc;

endmodule

/* src/vnfbm_div.sv */
`timescale 1ns / 1ps

module vnfbm_div import vnfbm_pkg::*; #(
    parameter int OCTAVES = OCTAVES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_ce,
    input  logic                  i_valid,
    input  logic [24+OCTAVES-1:0] i_y,
    output logic                  o_valid,
    output logic [23:0]           o_q
);

    localparam int YW = 24 + OCTAVES;
    localparam int DW = OCTAVES;
    localparam logic [DW-1:0] DIVISOR = DW'((1 << OCTAVES) - 1);
    localparam logic [YW:0]   RECIP   = (YW+1)'(((65'd1) << YW) / 65'(DIVISOR));

    // Stage 1: multiply by the truncated reciprocal
    logic        r_v1;
    logic [YW-1:0] r_y1;
    logic [2*YW:0] r_prod1;

    // Stage 2: estimate is low by at most one; fix with the remainder
    logic [23:0]   w_q0;
    logic [YW-1:0] w_back;
    logic [YW-1:0] w_rem;
    logic [23:0]   w_q;

    assign w_q0   = r_prod1[YW +: 24];
    assign w_back = YW'(w_q0) * YW'(DIVISOR);
    assign w_rem  = r_y1 - w_back;
    assign w_q    = (w_rem >= YW'(DIVISOR)) ? w_q0 + 24'd1 : w_q0;

    logic        r_v2;
    logic [23:0] r_q2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_ce) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_y1    <= i_y;
            r_prod1 <= (2*YW+1)'(i_y) * (2*YW+1)'(RECIP);
            r_q2    <= w_q;
        end
    end

    assign o_valid = r_v2;
    assign o_q     = r_q2;

endmodule

/* src/value_noise_fbm_1d_core.sv */
`timescale 1ns / 1ps
// One-dimensional fractal value noise, one sample per clock while not stalled.
//
// Input stream (i_s_*): each item is a signed Q16.16 position. Output stream
// (o_m_*): one Q0.24 noise value per input item, in input order. Both use a
// tvalid/tready handshake; an item moves on an edge where both are high.
// Config channel (i_cfg_*): a write sets the hash seed; it is always ready.
// Write it only while no items are in flight.
//
// Structure: a row of OCTAVES cells, one per octave. Each cell hashes the two
// lattice points of its octave, interpolates, and adds its weighted value to
// the running sum handed over from its left neighbor; the position moves one
// cell right in each cycle that the pipeline advances. A two-stage reciprocal
// divider normalizes the sum; an output register holds it for the receiver.
//
// Throughput: one item per cycle while the pipeline is not stalled, set by
// the fully pipelined cells.
// Stall: when the output register is full and not taken, the pipeline freezes
// only once its last stage also holds an item; empty slots keep draining.
// Reset: clears all valid bits and restores the seed to 1337.

module value_noise_fbm_1d_core import vnfbm_pkg::*; #(
    parameter int OCTAVES = OCTAVES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,      // noise_seed
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,       // [31:0] x_position
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata        // [23:0] noise_value
);

    localparam int AW = VAL_W + OCTAVES;
    localparam int YW = 24 + OCTAVES;

    // Seed held premultiplied by its hash constant
    logic [31:0] r_seed_mul;
    logic [63:0] w_seed_prod;

    assign w_seed_prod = 64'(i_cfg_data) * 64'(K_SEED_MUL);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_mul <= SEED_MUL_RESET;
        end else if (i_cfg_valid) begin
            r_seed_mul <= w_seed_prod[31:0];
        end
    end

    // Pipeline advance: hold only when the output is stuck and the last
    // divider stage has an item waiting behind it.
    logic w_out_free;
    logic w_ce;
    logic w_div_valid;
    logic [23:0] w_div_q;

    assign w_out_free = !o_m_tvalid || i_m_tready;
    assign w_ce       = w_out_free || !w_div_valid;
    assign o_s_tready = w_ce;

    // Cell row
    logic [OCTAVES:0]   w_valid;
    logic [31:0]        w_pos   [OCTAVES+1];
    logic [AW-1:0]      w_acc   [OCTAVES+1];
    logic [OCTAVES-1:0] w_acc_valid;

    assign w_valid[0] = i_s_tvalid;
    assign w_pos[0]   = i_s_tdata;
    assign w_acc[0]   = '0;

    for (genvar g = 0; g < OCTAVES; g++) begin : g_cell
        vnfbm_cell #(
            .OCTAVES (OCTAVES),
            .IDX     (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ce        (w_ce),
            .i_valid     (w_valid[g]),
            .i_pos       (w_pos[g]),
            .i_seed_mul  (r_seed_mul),
            .i_acc       (w_acc[g]),
            .o_valid     (w_valid[g+1]),
            .o_pos       (w_pos[g+1]),
            .o_acc_valid (w_acc_valid[g]),
            .o_acc       (w_acc[g+1])
        );
    end

    // Normalize: drop the 16 fraction bits of t, then divide by 2^OCTAVES - 1
    logic [YW-1:0] w_y;

    assign w_y = w_acc[OCTAVES][AW-1:16];

    vnfbm_div #(
        .OCTAVES (OCTAVES)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (w_acc_valid[OCTAVES-1]),
        .i_y     (w_y),
        .o_valid (w_div_valid),
        .o_q     (w_div_q)
    );

    // Output register
    logic        r_out_valid;
    logic [23:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out_data <= w_div_q;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import vnfbm_pkg::*;

    localparam int N_OCT      = OCTAVES_DEF;
    // Extra settling margin that wait_idle adds once the expected queue is empty.
    localparam int PIPE_LAT   = N_OCT + 5;
    // Cycles without any accepted item before the run is declared hung.
    localparam int STUCK_MAX  = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data;        // noise_seed
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;         // [31:0] x_position
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b1;
    logic [23:0] o_m_tdata;         // [23:0] noise_value

    // Seed as the core should hold it; changed only at a config accept.
    logic [31:0] seed_now = SEED_RESET;
    // Expected noise values, oldest first.
    logic [23:0] noise_q[$];
    logic [23:0] noise_want;
    int          fail_count  = 0;
    int          stuck_cycles = 0;
    int          stall_left  = 0;
    // Enables random gaps on the input side and stalls on the output side.
    bit          idle_on     = 1'b0;

    value_noise_fbm_1d_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // 24-bit lattice value of one integer lattice point, all arithmetic mod 2^32.
    function automatic logic [23:0] lattice_hash(input logic [31:0] lat_idx,
                                                 input logic [31:0] seed);
        logic [31:0] h;
        h = lat_idx * K_IDX_MUL + seed * K_SEED_MUL;
        h = (h ^ (h >> 13)) * K_MIX_MUL;
        h = h ^ (h >> 16);
        return h[23:0];
    endfunction

    // Fractal noise of one Q16.16 position: exact Q0.40 octave values,
    // weighted sum, truncating normalization to Q0.24.
    function automatic logic [23:0] fbm_noise(input logic [31:0] x,
                                              input logic [31:0] seed);
        logic [63:0] pos;
        logic [63:0] p;
        logic [63:0] acc;
        logic [63:0] q;
        logic [31:0] cell_lo;
        longint      a;
        longint      b;
        longint      t;
        longint      v;
        pos = {{32{x[31]}}, x};
        acc = '0;
        for (int i = 0; i < N_OCT; i++) begin
            p       = pos << i;
            cell_lo = p[47:16];
            t       = longint'(p[15:0]);
            a       = longint'(lattice_hash(cell_lo, seed));
            b       = longint'(lattice_hash(cell_lo + 32'd1, seed));
            v       = a * 65536 + (b - a) * t;
            acc     = acc + (64'(v) << (N_OCT - 1 - i));
        end
        q = acc / ((((64'd1) << N_OCT) - 64'd1) << 16);
        return q[23:0];
    endfunction

    // Send one position; with idling on, a random gap may come first.
    task automatic send_position(input logic [31:0] x);
        int gap;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= x;
        do @(posedge i_clk); while (!o_s_tready);
        noise_q = {noise_q, fbm_noise(x, seed_now)};
    endtask

    // Drop valid and wait until every expected value has come back.
    task automatic wait_idle();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (noise_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 2) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [31:0] seed);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= seed;
        do @(posedge i_clk); while (!o_cfg_ready);
        seed_now = seed;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Reset seed: zero, field extremes, smallest steps, negative fractions,
    // and the lattice index wrapping from all ones to zero.
    task automatic test_reset_seed();
        logic [31:0] pos_list[10];
        pos_list = '{32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_FFFF,
                     32'hFFFF_8000, 32'h8000_0001};
        foreach (pos_list[k]) send_position(pos_list[k]);
    endtask

    // Seed extremes, each with a wrap case, zero and a random position.
    task automatic test_seed_extremes();
        logic [31:0] seed_list[4];
        seed_list = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
        foreach (seed_list[k]) begin
            write_seed(seed_list[k]);
            send_position(32'h0000_0000);
            send_position(32'hFFFF_8000);
            send_position($urandom);
        end
    endtask

    // Mixed positions: full range, near zero, near the extremes, and walks
    // like a sample counter. Reseed now and then; idling switches in chunks.
    task automatic test_random_stream(input int n_items);
        logic [31:0] r;
        logic [31:0] walk;
        walk = $urandom;
        for (int k = 0; k < n_items; k++) begin
            if (k % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
            if (k % 110 == 109) write_seed($urandom);
            r = $urandom;
            case ($urandom_range(0, 3))
                0: begin
                    send_position(r);
                end
                1: begin
                    send_position({{13{r[31]}}, r[18:0]});
                end
                2: begin
                    send_position({r[31], {12{~r[31]}}, r[18:0]});
                end
                default: begin
                    walk = walk + $urandom_range(1, 32'h0002_0000);
                    send_position(walk);
                end
            endcase
        end
    endtask

    // Closing part: back to back at full rate, no gaps and no stalls.
    task automatic test_full_rate(input int n_items);
        idle_on = 1'b0;
        write_seed(SEED_RESET);
        for (int k = 0; k < n_items; k++) send_position($urandom);
    endtask

    // Receiver: random stall bursts while idling is on.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(1, 7) - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Compare each output item with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (noise_q.size() == 0) begin
                $error("noise_value: no item expected, got %h", o_m_tdata);
                fail_count++;
            end else begin
                noise_want = noise_q.pop_front();
                if (o_m_tdata !== noise_want) begin
                    $error("noise_value: expected %h, got %h", noise_want, o_m_tdata);
                    fail_count++;
                end
            end
        end
    end

    // Hang detection: count cycles in which nothing moves on any channel.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles + 1 >= STUCK_MAX) begin
            $display("value_noise_fbm_1d_core regression: fail");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_seed();
        test_seed_extremes();
        test_random_stream(340);
        test_full_rate(60);
        wait_idle();

        if (fail_count == 0) begin
            $display("value_noise_fbm_1d_core regression: pass");
        end else begin
            $display("value_noise_fbm_1d_core regression: fail");
        end
        $finish;
    end

endmodule

/* value_noise_fbm_1d_core.f */
src/vnfbm_pkg.sv
src/vnfbm_cell.sv
src/vnfbm_div.sv
src/value_noise_fbm_1d_core.sv
bench/testbench.sv
